// ===== hw/rtl/m4i_pkg.sv =====
// ----------------------------------------------------------------------------
// m4i_pkg
// Shared widths and request types for the 4x4 adjugate inverse unit.
// ----------------------------------------------------------------------------
package m4i_pkg;

  localparam int ELEMENT_WIDTH = 32;
  localparam int FRACTION_BITS = 16;
  localparam int EW = ELEMENT_WIDTH;
  localparam int FB = FRACTION_BITS;

  // Exact width of a determinant and of every cofactor, with headroom.
  localparam int PW = 4 * EW + 8;
  // Digit width of the shared multiplier and the digit count of one product.
  localparam int DW = 32;
  localparam int ND = (PW + DW - 1) / DW;
  // Dividend width: cofactor magnitude scaled by the fraction bits squared.
  localparam int NW = PW + 2 * FB;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 104;

  typedef struct packed {
    logic              start;
    logic signed [PW-1:0] x;
    logic signed [EW-1:0] e;
  } mul_req_t;

  typedef struct packed {
    logic          start;
    logic [NW-1:0] num;
    logic [PW-1:0] den;
  } div_req_t;

endpackage

// ===== hw/rtl/m4i_mul.sv =====
// ----------------------------------------------------------------------------
// m4i_mul
// Digit-serial signed multiplier: a wide operand times one element.
// ----------------------------------------------------------------------------
module m4i_mul
  import m4i_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  mul_req_t             req,
  output logic                 done,
  output logic signed [PW-1:0] prod
);

  localparam int XW = ND * DW;
  localparam int CW = (ND > 1) ? $clog2(ND) : 1;

  logic [XW-1:0]          x_r;
  logic signed [EW-1:0]   e_r;
  logic signed [PW-1:0]   acc_r;
  logic [CW-1:0]          cnt_r;
  logic                   run_r;
  logic                   done_r;

  logic [DW-1:0]          digit;
  logic signed [DW:0]     sd;
  logic signed [DW+EW:0]  pp;
  logic signed [PW-1:0]   pe;
  logic signed [PW-1:0]   shifted;

  always_comb begin
    digit   = x_r[cnt_r*DW +: DW];
    sd      = (cnt_r == CW'(ND - 1)) ? $signed({digit[DW-1], digit})
                                     : $signed({1'b0, digit});
    pp      = sd * e_r;
    pe      = PW'(pp);
    shifted = pe <<< (cnt_r * DW);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      if (req.start) begin
        x_r    <= XW'(req.x);
        e_r    <= req.e;
        acc_r  <= '0;
        cnt_r  <= '0;
        run_r  <= 1'b1;
        done_r <= 1'b0;
      end else if (run_r) begin
        acc_r <= acc_r + shifted;
        if (cnt_r == CW'(ND - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r  <= cnt_r + 1'b1;
          done_r <= 1'b0;
        end
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// ===== hw/rtl/m4i_div.sv =====
// ----------------------------------------------------------------------------
// m4i_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module m4i_div
  import m4i_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  div_req_t      req,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] num_r;
  logic [NW-1:0] quo_r;
  logic [PW:0]   rem_r;
  logic [PW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          run_r;
  logic          done_r;

  logic [PW:0]   rs;
  logic          ge;

  always_comb begin
    rs = {rem_r[PW-1:0], num_r[NW-1]};
    ge = (rs >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      if (req.start) begin
        num_r  <= req.num;
        den_r  <= req.den;
        rem_r  <= '0;
        quo_r  <= '0;
        cnt_r  <= CW'(NW);
        run_r  <= 1'b1;
        done_r <= 1'b0;
      end else if (run_r) begin
        rem_r <= ge ? (rs - {1'b0, den_r}) : rs;
        quo_r <= {quo_r[NW-2:0], ge};
        num_r <= {num_r[NW-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          done_r <= 1'b0;
        end
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== hw/rtl/matrix4_inverse_adjugate_unit.sv =====
// ----------------------------------------------------------------------------
// matrix4_inverse_adjugate_unit
// 4x4 fixed-point matrix inverse by the adjugate, on shared arithmetic.
// ----------------------------------------------------------------------------
// Elements are taken one per cycle while the unit is idle; each transfer is
// stored at its index. A transfer with tlast set on a complete matrix starts
// the run, and no input is taken until its last result has been transferred.
// The sixteen cofactors need 192 products and the determinant four more, each
// made of digit passes of the 33 by 32 bit multiplier over five digits, and
// each cofactor term first fetches its first element; the sixteen quotients
// then come from the bit-serial divider, which yields 168 quotient bits each,
// and a result is held in its output state until it is transferred. A
// singular matrix ends after the determinant with a single result.
module matrix4_inverse_adjugate_unit
  import m4i_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // element_value [31:0], element_index [35:32]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // out_index [3:0], inverse_value [35:4], determinant_value [99:36]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // invertible [0], saturated [1]
  output logic [1:0]             out_tuser,
  output logic                   out_tlast
);

  typedef enum logic [3:0] {
    S_IDLE, S_COF_A, S_COF_S1, S_COF_W1, S_COF_S2, S_COF_W2,
    S_DET_S, S_DET_W, S_CHECK, S_DSAT, S_DIV_S, S_DIV_W, S_OUT
  } state_t;

  state_t               state_r;
  logic [15:0]          mask_r;
  logic [3:0]           k_r;
  logic [2:0]           t_r;
  logic signed [PW-1:0] acc_r;
  logic signed [EW-1:0] a_r;
  logic signed [PW-1:0] cof_r [16];
  logic [PW-1:0]        dmag_r;
  logic                 dneg_r;
  logic                 neg_r;
  logic                 dclip_r;
  logic [63:0]          detv_r;
  logic                 out_valid_r;
  logic [3:0]           out_index_r;
  logic [EW-1:0]        inv_r;
  logic                 invertible_r;
  logic                 sat_r;
  logic                 last_r;

  logic signed [EW-1:0] mem [16];

  mul_req_t             mul_req;
  logic                 mul_done;
  logic signed [PW-1:0] mul_p;
  div_req_t             div_req;
  logic                 div_done;
  logic [NW-1:0]        div_q;

  logic                 in_acc;
  logic [3:0]           in_idx;
  logic [15:0]          mask_new;
  logic [3:0]           rd_addr;
  logic signed [EW-1:0] rd_data;
  logic [5:0]           perm;
  logic                 term_neg;
  logic [1:0]           row_r;
  logic [1:0]           col_c;
  logic signed [PW-1:0] acc_nxt;
  logic signed [PW-1:0] cof_sel;
  logic [PW-1:0]        dq;
  logic [PW-1:0]        dlim;
  logic [NW-1:0]        qlim;
  logic [NW-1:0]        qsat;
  logic [NW-1:0]        qsgn;
  logic [63:0]          dval;

  function automatic logic [1:0] skip(input logic [1:0] x, input logic [1:0] r);
    return (x >= r) ? x + 2'd1 : x;
  endfunction

  function automatic logic [5:0] perm_sel(input logic [2:0] t);
    logic [5:0] p;
    unique case (t)
      3'd0:    p = {2'd0, 2'd1, 2'd2};
      3'd1:    p = {2'd0, 2'd2, 2'd1};
      3'd2:    p = {2'd1, 2'd0, 2'd2};
      3'd3:    p = {2'd1, 2'd2, 2'd0};
      3'd4:    p = {2'd2, 2'd0, 2'd1};
      3'd5:    p = {2'd2, 2'd1, 2'd0};
      default: p = {2'd0, 2'd1, 2'd2};
    endcase
    return p;
  endfunction

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_idx    = in_tdata[35:32];
  assign mask_new  = mask_r | (16'd1 << in_idx);

  always_comb begin
    perm     = perm_sel(t_r);
    term_neg = (t_r == 3'd1) || (t_r == 3'd2) || (t_r == 3'd5);
    row_r    = k_r[3:2];
    col_c    = k_r[1:0];
    unique case (state_r)
      S_COF_A:  rd_addr = {skip(2'd2, row_r), skip(perm[1:0], col_c)};
      S_COF_S1: rd_addr = {skip(2'd1, row_r), skip(perm[3:2], col_c)};
      S_COF_S2: rd_addr = {skip(2'd0, row_r), skip(perm[5:4], col_c)};
      default:  rd_addr = {2'd0, k_r[1:0]};
    endcase
    rd_data = mem[rd_addr];
    acc_nxt = term_neg ? (acc_r - mul_p) : (acc_r + mul_p);
    cof_sel = (state_r == S_DIV_S) ? cof_r[{k_r[1:0], k_r[3:2]}] : cof_r[k_r];

    mul_req.start = 1'b0;
    mul_req.x     = PW'(rd_data);
    mul_req.e     = a_r;
    unique case (state_r)
      S_COF_S1: mul_req.start = 1'b1;
      S_COF_S2: begin
        mul_req.start = 1'b1;
        mul_req.x     = mul_p;
        mul_req.e     = rd_data;
      end
      S_DET_S: begin
        mul_req.start = 1'b1;
        mul_req.x     = cof_sel;
        mul_req.e     = rd_data;
      end
      default: ;
    endcase

    div_req.start = (state_r == S_DIV_S);
    div_req.num   = NW'(cof_sel[PW-1] ? -cof_sel : cof_sel) << (2 * FB);
    div_req.den   = dmag_r;

    dq   = dmag_r >> (2 * FB);
    dlim = dneg_r ? (PW'(1) << 63) : ((PW'(1) << 63) - PW'(1));
    dval = (dq > dlim) ? dlim[63:0] : dq[63:0];

    qlim = neg_r ? (NW'(1) << (EW - 1)) : ((NW'(1) << (EW - 1)) - NW'(1));
    qsat = (div_q > qlim) ? qlim : div_q;
    qsgn = neg_r ? -qsat : qsat;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mem[in_idx] <= $signed(in_tdata[EW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_tlast && (mask_new == 16'hFFFF)) begin
              mask_r  <= '0;
              k_r     <= '0;
              t_r     <= '0;
              acc_r   <= '0;
              state_r <= S_COF_A;
            end else begin
              mask_r <= mask_new;
            end
          end
        end
        S_COF_A: begin
          a_r     <= rd_data;
          state_r <= S_COF_S1;
        end
        S_COF_S1: state_r <= S_COF_W1;
        S_COF_W1: if (mul_done) state_r <= S_COF_S2;
        S_COF_S2: state_r <= S_COF_W2;
        S_COF_W2: begin
          if (mul_done) begin
            if (t_r == 3'd5) begin
              cof_r[k_r] <= (row_r[0] ^ col_c[0]) ? -acc_nxt : acc_nxt;
              acc_r      <= '0;
              t_r        <= '0;
              k_r        <= k_r + 4'd1;
              state_r    <= (k_r == 4'd15) ? S_DET_S : S_COF_A;
            end else begin
              acc_r   <= acc_nxt;
              t_r     <= t_r + 3'd1;
              state_r <= S_COF_A;
            end
          end
        end
        S_DET_S: state_r <= S_DET_W;
        S_DET_W: begin
          if (mul_done) begin
            acc_r   <= acc_r + mul_p;
            k_r     <= k_r + 4'd1;
            state_r <= (k_r == 4'd3) ? S_CHECK : S_DET_S;
          end
        end
        S_CHECK: begin
          k_r <= '0;
          if (acc_r == '0) begin
            out_index_r  <= '0;
            inv_r        <= '0;
            detv_r       <= '0;
            invertible_r <= 1'b0;
            sat_r        <= 1'b0;
            last_r       <= 1'b1;
            out_valid_r  <= 1'b1;
            state_r      <= S_OUT;
          end else begin
            dneg_r  <= acc_r[PW-1];
            dmag_r  <= acc_r[PW-1] ? -acc_r : acc_r;
            state_r <= S_DSAT;
          end
        end
        S_DSAT: begin
          detv_r  <= dneg_r ? -dval : dval;
          dclip_r <= (dq > dlim);
          state_r <= S_DIV_S;
        end
        S_DIV_S: begin
          neg_r   <= cof_sel[PW-1] ^ dneg_r;
          state_r <= S_DIV_W;
        end
        S_DIV_W: begin
          if (div_done) begin
            out_index_r  <= k_r;
            inv_r        <= qsgn[EW-1:0];
            invertible_r <= 1'b1;
            sat_r        <= (div_q > qlim) || dclip_r;
            last_r       <= (k_r == 4'd15);
            out_valid_r  <= 1'b1;
            state_r      <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_tready) begin
            out_valid_r <= 1'b0;
            k_r         <= k_r + 4'd1;
            state_r     <= last_r ? S_IDLE : S_DIV_S;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  m4i_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .done  (mul_done),
    .prod  (mul_p)
  );

  m4i_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quo   (div_q)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, detv_r, 32'(inv_r), out_index_r};
  assign out_tuser  = {sat_r, invertible_r};
  assign out_tlast  = last_r;

  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("Input ready while a result is pending.");

  a_mask_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (mask_r == '0))
    else $error("Load mask not cleared during a run.");

  a_singular_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> out_tlast)
    else $error("Singular result is not the last of its run.");

  a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == S_COF_W1 || state_r == S_COF_W2 || state_r == S_DET_W))
    else $error("Product completed outside a wait state.");

endmodule
